[rtl/core/hpd_pkg.sv]
// Shared types, constants and code-table functions of the HPACK Huffman decoder.
package hpd_pkg;

	localparam int STORE_BITS_DEF = 40;
	localparam int MAX_CODE_LEN   = 30;
	localparam int PAD_MAX        = 7;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_byte;
	} hpd_item_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DEC,
		ST_EMIT,
		ST_END
	} hpd_state_t;

	// number of codes of each length, index 0..30; length 30 includes EOS
	localparam logic [5:0] LEN_COUNT [0:MAX_CODE_LEN] = '{
		6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd10, 6'd26, 6'd32, 6'd6, 6'd0, 6'd5,
		6'd3, 6'd2, 6'd6, 6'd2, 6'd3, 6'd0, 6'd0, 6'd0, 6'd3, 6'd8,
		6'd13, 6'd26, 6'd29, 6'd12, 6'd4, 6'd15, 6'd19, 6'd29, 6'd0, 6'd4
	};

	// octets in canonical order: by code length, then by value
	localparam logic [7:0] SORTED_SYM [0:255] = '{
		8'd48, 8'd49, 8'd50, 8'd97, 8'd99, 8'd101, 8'd105, 8'd111, 8'd115, 8'd116,
		8'd32, 8'd37, 8'd45, 8'd46, 8'd47, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
		8'd56, 8'd57, 8'd61, 8'd65, 8'd95, 8'd98,
		8'd100, 8'd102, 8'd103, 8'd104, 8'd108, 8'd109, 8'd110, 8'd112, 8'd114, 8'd117,
		8'd58, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74,
		8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80,
		8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd89, 8'd106, 8'd107,
		8'd113, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122,
		8'd38, 8'd42, 8'd44, 8'd59, 8'd88, 8'd90,
		8'd33, 8'd34, 8'd40, 8'd41, 8'd63,
		8'd39, 8'd43, 8'd124,
		8'd35, 8'd62,
		8'd0, 8'd36, 8'd64, 8'd91, 8'd93, 8'd126,
		8'd94, 8'd125,
		8'd60, 8'd96, 8'd123,
		8'd92, 8'd195, 8'd208,
		8'd128, 8'd130, 8'd131, 8'd162, 8'd184, 8'd194, 8'd224, 8'd226,
		8'd153, 8'd161, 8'd167, 8'd172, 8'd176, 8'd177, 8'd179, 8'd209, 8'd216,
		8'd217, 8'd227, 8'd229, 8'd230,
		8'd129, 8'd132, 8'd133, 8'd134, 8'd136, 8'd146, 8'd154, 8'd156, 8'd160,
		8'd163, 8'd164, 8'd169, 8'd170,
		8'd173, 8'd178, 8'd181, 8'd185, 8'd186, 8'd187, 8'd189, 8'd190, 8'd196,
		8'd198, 8'd228, 8'd232, 8'd233,
		8'd1, 8'd135, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd143, 8'd147,
		8'd149, 8'd150, 8'd151, 8'd152, 8'd155, 8'd157,
		8'd158, 8'd165, 8'd166, 8'd168, 8'd174, 8'd175, 8'd180, 8'd182, 8'd183,
		8'd188, 8'd191, 8'd197, 8'd231, 8'd239,
		8'd9, 8'd142, 8'd144, 8'd145, 8'd148, 8'd159, 8'd171, 8'd206, 8'd215,
		8'd225, 8'd236, 8'd237,
		8'd199, 8'd207, 8'd234, 8'd235,
		8'd192, 8'd193, 8'd200, 8'd201, 8'd202, 8'd205, 8'd210, 8'd213, 8'd218,
		8'd219, 8'd238, 8'd240, 8'd242, 8'd243, 8'd255,
		8'd203, 8'd204, 8'd211, 8'd212, 8'd214, 8'd221, 8'd222, 8'd223, 8'd241,
		8'd244, 8'd245, 8'd246, 8'd247, 8'd248,
		8'd250, 8'd251, 8'd252, 8'd253, 8'd254,
		8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11, 8'd12, 8'd14, 8'd15,
		8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd23, 8'd24,
		8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd127, 8'd220, 8'd249,
		8'd10, 8'd13, 8'd22
	};

	// first canonical code of length len
	function automatic logic [30:0] hd_first(input int len);
		logic [30:0] f;
		f = '0;
		for (int i = 1; i < len; i++) begin
			f = (f + 31'(LEN_COUNT[i])) << 1;
		end
		return f;
	endfunction

	// index in SORTED_SYM of the first code of length len
	function automatic logic [8:0] hd_base(input int len);
		logic [8:0] b;
		b = '0;
		for (int i = 1; i < len; i++) begin
			b = b + 9'(LEN_COUNT[i]);
		end
		return b;
	endfunction

endpackage

[rtl/core/hpd_in_queue.sv]
// Two-entry input queue that decouples the stream slave from the decode engine.
module hpd_in_queue
	import hpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  hpd_item_t wr_item,
	output logic      rd_valid,
	input  logic      rd_pop,
	output hpd_item_t rd_item
);

	hpd_item_t  slot_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;
	logic       push;
	logic       pop;

	assign wr_ready = (level_q != 2'd2);
	assign rd_valid = (level_q != 2'd0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			level_q <= level_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[rtl/core/hpd_decode.sv]
// Decode engine: bit accumulator, canonical code match, symbol lookup, result register.
module hpd_decode
	import hpd_pkg::*;
#(
	parameter int STORE_BITS = STORE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  hpd_item_t  item,
	output logic       item_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic [1:0] m_tuser
);

	localparam int W = STORE_BITS;

	hpd_state_t state_q, state_d;

	logic [W-1:0] store_q;          // left aligned, head code at the top
	logic [5:0]   count_q;
	logic         err_q;
	logic         last_q;
	logic         n_q;
	logic         hit_q;
	logic [4:0]   len_q;
	logic [8:0]   idx_q;

	logic         out_valid_q;
	logic [7:0]   out_sym_q;
	logic         out_symv_q;
	logic         out_end_q;
	logic         out_err_q;

	logic         out_free;
	logic         do_append, do_dec, do_shift, do_clear, do_err, do_emit_sym, do_emit_end;
	logic         n_set, n_inc;

	logic [MAX_CODE_LEN:1] hit;
	logic [30:0]  first_a [1:MAX_CODE_LEN];
	logic [8:0]   base_a  [1:MAX_CODE_LEN];
	logic         hit_any;
	logic [4:0]   len_d;
	logic [29:0]  code30;
	logic [29:0]  code_l;
	logic [29:0]  diff;
	logic [8:0]   idx_d;
	logic [W-1:0] byte_ext;
	logic [7:0]   pad_mask;
	logic         pad_bad;

	for (genvar l = 1; l <= MAX_CODE_LEN; l++) begin : g_len
		localparam logic [30:0] FIRST = hd_first(l);
		localparam logic [30:0] LIM   = FIRST + 31'(LEN_COUNT[l]);
		assign first_a[l] = FIRST;
		assign base_a[l]  = hd_base(l);
		if (LEN_COUNT[l] == 6'd0) begin : g_none
			assign hit[l] = 1'b0;
		end else begin : g_cmp
			assign hit[l] = (count_q >= 6'(l)) &&
				({{(31-l){1'b0}}, store_q[W-1 -: l]} < LIM);
		end
	end

	// shortest matching length wins; longer lengths match too, and canonical order makes the shortest the code's length
	always_comb begin
		len_d = '0;
		for (int l = MAX_CODE_LEN; l >= 1; l--) begin
			if (hit[l]) len_d = 5'(l);
		end
	end

	assign hit_any = |hit;
	assign code30  = store_q[W-1 -: 30];
	assign code_l  = code30 >> (5'd30 - len_d);
	assign diff    = code_l - first_a[len_d][29:0];
	assign idx_d   = base_a[len_d] + diff[8:0];

	assign byte_ext = {item.code_byte, {(W-8){1'b0}}} >> count_q;
	assign pad_mask = ~(8'hFF >> count_q[2:0]);
	assign pad_bad  = (count_q > 6'(PAD_MAX)) || ((store_q[W-1 -: 8] & pad_mask) != pad_mask);

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d     = state_q;
		item_pop    = 1'b0;
		do_append   = 1'b0;
		do_dec      = 1'b0;
		do_shift    = 1'b0;
		do_clear    = 1'b0;
		do_err      = 1'b0;
		do_emit_sym = 1'b0;
		do_emit_end = 1'b0;
		n_set       = 1'b0;
		n_inc       = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (item_valid) begin
					item_pop = 1'b1;
					if (err_q) begin
						state_d = item.last_byte ? ST_END : ST_LOAD;
					end else begin
						do_append = 1'b1;
						n_set     = 1'b1;
						state_d   = ST_DEC;
					end
				end
			end
			ST_DEC: begin
				do_dec  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!hit_q) begin
					state_d = last_q ? ST_END : ST_LOAD;
				end else if (idx_q[8]) begin
					// EOS code: drop the rest of the string
					do_err   = 1'b1;
					do_clear = 1'b1;
					state_d  = last_q ? ST_END : ST_LOAD;
				end else if (out_free) begin
					do_emit_sym = 1'b1;
					do_shift    = 1'b1;
					n_inc       = 1'b1;
					if (n_q) state_d = last_q ? ST_END : ST_LOAD;
					else     state_d = ST_DEC;
				end
			end
			ST_END: begin
				if (out_free) begin
					do_emit_end = 1'b1;
					do_clear    = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q     <= '0;
			count_q     <= '0;
			err_q       <= 1'b0;
			last_q      <= 1'b0;
			n_q         <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_pop) last_q <= item.last_byte;
			if (do_append) begin
				store_q <= store_q | byte_ext;
				count_q <= count_q + 6'd8;
			end
			if (do_shift) begin
				store_q <= store_q << len_q;
				count_q <= count_q - 6'(len_q);
			end
			if (do_clear) begin
				store_q <= '0;
				count_q <= '0;
				err_q   <= 1'b0;
			end
			if (do_err) err_q <= 1'b1;
			if (n_set)  n_q <= 1'b0;
			if (n_inc)  n_q <= 1'b1;
			if (do_dec) hit_q <= hit_any;
			if (do_emit_sym || do_emit_end) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_dec) begin
			len_q <= len_d;
			idx_q <= idx_d;
		end
		if (do_emit_sym) begin
			out_sym_q  <= SORTED_SYM[idx_q[7:0]];
			out_symv_q <= 1'b1;
			out_end_q  <= 1'b0;
			out_err_q  <= 1'b0;
		end
		if (do_emit_end) begin
			out_sym_q  <= 8'h00;
			out_symv_q <= 1'b0;
			out_end_q  <= 1'b1;
			out_err_q  <= err_q || pad_bad;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sym_q;
	assign m_tlast  = out_end_q;
	assign m_tuser  = {out_err_q, out_symv_q};

endmodule

[rtl/core/hpack_huffman_decoder.sv]
// Top level of the HPACK static Huffman string decoder.
// One coded byte per transaction enters on s_*, MSB first, s_tlast on the string's last byte;
// decoded octets leave on m_*, followed by one end transaction (m_tlast high, m_tuser[0] low)
// whose m_tuser[1] flags bad padding or an EOS code earlier in the string. A two-entry
// queue takes bytes while the engine works. The engine loads a byte, then runs code
// lookups, each a length match and then a table read. A byte with no complete code
// ends after one lookup. After the first symbol a second lookup follows, and no more than
// two symbols are decoded per loaded byte. A string's last byte adds the end transaction.
// Bytes that arrive after an error are popped and dropped. Code lookup is serial, one
// symbol at a time. Output stalls hold the engine.
module hpack_huffman_decoder
	import hpd_pkg::*;
#(
	parameter int STORE_BITS = STORE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] code_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] symbol
	output logic       m_tlast,   // string_end
	output logic [1:0] m_tuser    // [0] symbol_valid, [1] decode_error
);

	hpd_item_t in_item;
	hpd_item_t q_item;
	logic      q_valid;
	logic      q_pop;

	assign in_item.code_byte = s_tdata;
	assign in_item.last_byte = s_tlast;

	hpd_in_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_tvalid),
		.wr_ready (s_tready),
		.wr_item  (in_item),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_item  (q_item)
	);

	hpd_decode #(
		.STORE_BITS (STORE_BITS)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.item_pop   (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	a_end_no_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tuser[0] && (m_tdata == 8'h00))
		else $error("end transaction carries a symbol");

	a_mid_is_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[0])
		else $error("non-end transaction without a symbol");

	a_symbol_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1])
		else $error("symbol transaction flags an error");

endmodule
